>>> sv/swrl_pkg.sv
`default_nettype none

package swrl_pkg;

  localparam int unsigned KEY_W     = 4;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned WINDOW_W  = 31;
  localparam int unsigned OCC_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 31;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_API_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd2;

  localparam logic [LIMIT_W-1:0]  DEFAULT_LIMIT  = 7'd60;
  localparam logic [WINDOW_W-1:0] DEFAULT_WINDOW = 31'd60000;

  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  key_index;
    logic [TIME_W-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic             admitted;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic clr;
    logic load_req;
    logic load_meta;
    logic evict;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic meta_empty;
    logic stale;
    logic last;
  } status_t;

endpackage

`default_nettype wire

>>> sv/swrl_ctrl.sv
`default_nettype none

module swrl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire swrl_pkg::status_t status_i,
  output swrl_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META_RD,
    ST_META_LD,
    ST_EVICT,
    ST_DECIDE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_META_RD;
        end
      end
      ST_META_RD: begin
        state_d = ST_META_LD;
      end
      ST_META_LD: begin
        cmd_o.load_meta = 1'b1;
        state_d         = status_i.meta_empty ? ST_DECIDE : ST_EVICT;
      end
      ST_EVICT: begin
        if (status_i.stale) begin
          cmd_o.evict = 1'b1;
          if (status_i.last) begin
            state_d = ST_DECIDE;
          end
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result committed over a beat not yet taken");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in flight");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DECIDE)
    else $error("result raised outside the decision step");

endmodule

`default_nettype wire

>>> sv/swrl_dp.sv
`default_nettype none

module swrl_dp #(
  parameter int unsigned KEYS_PER_CLASS = 16,
  parameter int unsigned MAX_LIMIT      = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [swrl_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire swrl_pkg::req_t                  in_data_i,
  input  wire swrl_pkg::cmd_t                  cmd_i,
  output swrl_pkg::status_t                    status_o,
  output swrl_pkg::rsp_t                       out_data_o
);

  localparam int unsigned RINGS   = 2 * KEYS_PER_CLASS;
  localparam int unsigned RING_W  = $clog2(RINGS);
  localparam int unsigned KSEL_W  = (KEYS_PER_CLASS > 1) ? $clog2(KEYS_PER_CLASS) : 1;
  localparam int unsigned SLOT_W  = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_LIMIT + 1);
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned LIM_W   = (CNT_W > swrl_pkg::LIMIT_W) ? CNT_W : swrl_pkg::LIMIT_W;
  localparam int unsigned META_W  = SLOT_W + CNT_W;
  localparam int unsigned DEPTH   = RINGS * MAX_LIMIT;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned KEYS_IN = 2 ** swrl_pkg::KEY_W;

  // configuration
  logic [swrl_pkg::LIMIT_W-1:0]  api_limit_q, addr_limit_q;
  logic [swrl_pkg::WINDOW_W-1:0] window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      api_limit_q  <= swrl_pkg::DEFAULT_LIMIT;
      addr_limit_q <= swrl_pkg::DEFAULT_LIMIT;
      window_q     <= swrl_pkg::DEFAULT_WINDOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        swrl_pkg::CFG_API_LIMIT:    api_limit_q  <= cfg_data_i[swrl_pkg::LIMIT_W-1:0];
        swrl_pkg::CFG_ADDR_LIMIT:   addr_limit_q <= cfg_data_i[swrl_pkg::LIMIT_W-1:0];
        swrl_pkg::CFG_WINDOW_TICKS: window_q     <= cfg_data_i[swrl_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass over the ring table after reset
  logic [RING_W-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
    end else if (cmd_i.clr) begin
      clr_idx_q <= clr_idx_q + RING_W'(1);
    end
  end

  // request capture
  logic [KSEL_W-1:0]           key_mod;
  logic [RING_W-1:0]           ring_in;
  logic [RING_W-1:0]           ring_q;
  logic                        mode_q;
  logic [swrl_pkg::TIME_W-1:0] now_q;
  logic [ADDR_W-1:0]           base_q;

  always_comb begin
    key_mod = '0;
    for (int i = 0; i < KEYS_IN; i++) begin
      if (in_data_i.key_index == swrl_pkg::KEY_W'(i)) begin
        key_mod = KSEL_W'(i % KEYS_PER_CLASS);
      end
    end
    ring_in = RING_W'(key_mod) + (in_data_i.mode ? RING_W'(KEYS_PER_CLASS) : RING_W'(0));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      ring_q <= ring_in;
      mode_q <= in_data_i.mode;
      now_q  <= in_data_i.now_time;
    end
    base_q <= ADDR_W'(ring_q) * ADDR_W'(MAX_LIMIT);
  end

  // ring table: head and count per key
  logic [META_W-1:0] meta_mem [RINGS];
  logic [META_W-1:0] meta_rdata_q;
  logic [SLOT_W-1:0] meta_head;
  logic [CNT_W-1:0]  meta_count;

  assign meta_head  = meta_rdata_q[META_W-1:CNT_W];
  assign meta_count = meta_rdata_q[CNT_W-1:0];

  // working head and count
  logic [SLOT_W-1:0] head_q, head_inc;
  logic [CNT_W-1:0]  count_q, count_new;
  logic [LIM_W-1:0]  lim_raw, lim_sat;
  logic              admit;
  logic [SUM_W-1:0]  slot_sum;
  logic [SLOT_W-1:0] slot;

  always_comb begin
    head_inc = (head_q == SLOT_W'(MAX_LIMIT - 1)) ? SLOT_W'(0) : head_q + SLOT_W'(1);
    lim_raw  = LIM_W'(mode_q ? addr_limit_q : api_limit_q);
    lim_sat  = (lim_raw > LIM_W'(MAX_LIMIT)) ? LIM_W'(MAX_LIMIT) : lim_raw;
    admit    = LIM_W'(count_q) < lim_sat;
    count_new = admit ? count_q + CNT_W'(1) : count_q;
    // head below depth and count at most depth, so one subtract wraps the slot
    slot_sum = SUM_W'(head_q) + SUM_W'(count_q);
    if (slot_sum >= SUM_W'(MAX_LIMIT)) begin
      slot_sum = slot_sum - SUM_W'(MAX_LIMIT);
    end
    slot = SLOT_W'(slot_sum);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_meta) begin
      head_q  <= meta_head;
      count_q <= meta_count;
    end else if (cmd_i.evict) begin
      head_q  <= head_inc;
      count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      meta_mem[clr_idx_q] <= '0;
    end else if (cmd_i.commit) begin
      meta_mem[ring_q] <= {head_q, count_new};
    end
    meta_rdata_q <= meta_mem[ring_q];
  end

  // timestamp store
  logic [swrl_pkg::TIME_W-1:0] stamp_mem [DEPTH];
  logic [swrl_pkg::TIME_W-1:0] stamp_rdata_q;
  logic [ADDR_W-1:0]           stamp_raddr;
  logic [swrl_pkg::TIME_W-1:0] age;

  // next stamp read follows the head one entry a cycle while evicting
  assign stamp_raddr = base_q + ADDR_W'(cmd_i.load_meta ? meta_head : head_inc);
  assign age         = now_q - stamp_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && admit) begin
      stamp_mem[base_q + ADDR_W'(slot)] <= now_q;
    end
    stamp_rdata_q <= stamp_mem[stamp_raddr];
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_o.admitted  <= admit;
      out_data_o.occupancy <= swrl_pkg::OCC_W'(count_new);
    end
  end

  always_comb begin
    status_o.clr_last   = (clr_idx_q == RING_W'(RINGS - 1));
    status_o.meta_empty = (meta_count == CNT_W'(0));
    status_o.stale      = age > {1'b0, window_q};
    status_o.last       = (count_q == CNT_W'(1));
  end

  a_evict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> count_q != CNT_W'(0))
    else $error("eviction from an empty ring");

  a_meta_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_meta |-> meta_count <= CNT_W'(MAX_LIMIT))
    else $error("ring count above capacity");

endmodule

`default_nettype wire

>>> sv/sliding_window_rate_limiter.sv
// Per-key sliding-window-log rate limiter. Each request beat names a class
// (API key or client address), a key and the current tick count; the block
// evicts that key's stamps older than the window, then admits and logs the
// request if the ring holds fewer than the class limit. One request is in
// flight at a time; ready returns once the result is committed, after the
// ring table read, an eviction loop in which the stamp memory read steps
// one ring entry per cycle (it ends on the first live entry or an empty
// ring, at most MAX_LIMIT entries evicted) and the decision step. A result
// beat not yet taken holds the block in its final step. After reset a
// clearing pass zeroes the ring table; no request is taken during it,
// configuration writes are. Limits above MAX_LIMIT saturate, key_index is
// taken modulo KEYS_PER_CLASS.
`default_nettype none

module sliding_window_rate_limiter #(
  parameter int unsigned KEYS_PER_CLASS = 16,
  parameter int unsigned MAX_LIMIT      = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [swrl_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire swrl_pkg::req_t                  in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output swrl_pkg::rsp_t                       out_data_o
);

  swrl_pkg::cmd_t    cmd;
  swrl_pkg::status_t status;

  swrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  swrl_dp #(
    .KEYS_PER_CLASS (KEYS_PER_CLASS),
    .MAX_LIMIT      (MAX_LIMIT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> sim/sliding_window_rate_limiter_test.sv
`default_nettype none

module sliding_window_rate_limiter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEYS          = 16;
  localparam int unsigned DEPTH         = 64;
  localparam int unsigned RINGS         = 2 * KEYS;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [swrl_pkg::CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [swrl_pkg::CFG_W-1:0]     cfg_data_i  = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  swrl_pkg::req_t                 in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  swrl_pkg::rsp_t                 out_data_o;

  sliding_window_rate_limiter #(
    .KEYS_PER_CLASS(KEYS),
    .MAX_LIMIT     (DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // shadow of the per-key stamp rings and registers
  logic [swrl_pkg::TIME_W-1:0]   stamp_log [RINGS][DEPTH];
  int unsigned                   ring_oldest [RINGS];
  int unsigned                   ring_fill [RINGS];
  logic [swrl_pkg::LIMIT_W-1:0]  lim_api    = swrl_pkg::DEFAULT_LIMIT;
  logic [swrl_pkg::LIMIT_W-1:0]  lim_addr   = swrl_pkg::DEFAULT_LIMIT;
  logic [swrl_pkg::WINDOW_W-1:0] window_len = swrl_pkg::DEFAULT_WINDOW;

  swrl_pkg::req_t pending_reqs [$];
  swrl_pkg::rsp_t expected_rsps [$];

  logic [swrl_pkg::TIME_W-1:0] now_cursor = '0;
  int unsigned req_gap       = 0;
  int unsigned in_calm       = 0;
  int unsigned result_hold   = 0;
  int unsigned out_calm      = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned errors        = 0;
  int unsigned reqs_accepted = 0;
  int unsigned admits_seen   = 0;
  int unsigned refusals_seen = 0;
  int unsigned settings_used = 1;

  function automatic swrl_pkg::rsp_t admit_request(swrl_pkg::req_t r);
    int unsigned                 ring;
    int unsigned                 lim;
    int unsigned                 oldest;
    int unsigned                 fill;
    logic [swrl_pkg::TIME_W-1:0] age;
    logic                        live;
    swrl_pkg::rsp_t              res;
    ring   = (r.mode ? KEYS : 0) + (int'(r.key_index) % KEYS);
    lim    = r.mode ? 32'(lim_addr) : 32'(lim_api);
    if (lim > DEPTH) lim = DEPTH;
    oldest = ring_oldest[ring];
    fill   = ring_fill[ring];
    live   = 1'b0;
    // drop stale stamps oldest first, modular age
    while (fill > 0 && !live) begin
      age = r.now_time - stamp_log[ring][oldest];
      if (age <= {1'b0, window_len}) begin
        live = 1'b1;
      end else begin
        oldest = (oldest + 1) % DEPTH;
        fill--;
      end
    end
    res.admitted = 1'b0;
    if (fill < lim) begin
      stamp_log[ring][(oldest + fill) % DEPTH] = r.now_time;
      fill++;
      res.admitted = 1'b1;
    end
    ring_oldest[ring] = oldest;
    ring_fill[ring]   = fill;
    res.occupancy     = swrl_pkg::OCC_W'(fill);
    return res;
  endfunction

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(15, 0) == 0) begin
      calm = $urandom_range(40, 10);
      return 0;
    end
    return $urandom_range(11, 0);
  endfunction

  function automatic logic [swrl_pkg::CFG_W-1:0] pick_limit();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return swrl_pkg::CFG_W'(DEPTH);
      2: return swrl_pkg::CFG_W'($urandom_range(127, DEPTH + 1));
      3: return swrl_pkg::CFG_W'(1);
      default: return swrl_pkg::CFG_W'($urandom_range(8, 1));
    endcase
  endfunction

  function automatic logic [swrl_pkg::CFG_W-1:0] pick_window();
    case ($urandom_range(7, 0))
      0: return 31'h7FFF_FFFF;
      1: return swrl_pkg::CFG_W'($urandom);
      2: return swrl_pkg::CFG_W'(1);
      default: return swrl_pkg::CFG_W'($urandom_range(2000, 2));
    endcase
  endfunction

  task automatic write_reg(logic [swrl_pkg::CFG_IDX_W-1:0] idx,
                           logic [swrl_pkg::CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      swrl_pkg::CFG_API_LIMIT:    lim_api    = value[swrl_pkg::LIMIT_W-1:0];
      swrl_pkg::CFG_ADDR_LIMIT:   lim_addr   = value[swrl_pkg::LIMIT_W-1:0];
      swrl_pkg::CFG_WINDOW_TICKS: window_len = value[swrl_pkg::WINDOW_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic queue_req(logic mode, logic [swrl_pkg::KEY_W-1:0] key,
                           logic [swrl_pkg::TIME_W-1:0] t);
    swrl_pkg::req_t r;
    r.mode      = mode;
    r.key_index = key;
    r.now_time  = t;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // every queued beat taken and answered, then a short pause
  task automatic settle();
    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_traffic(int unsigned count, int unsigned hot_pct,
                                logic long_jumps, logic [swrl_pkg::TIME_W-1:0] step_cap);
    logic [4:0]                  hot_a;
    logic [4:0]                  hot_b;
    logic [4:0]                  ring;
    logic [swrl_pkg::TIME_W-1:0] w;
    logic [swrl_pkg::TIME_W-1:0] step_max;
    int unsigned                 pick;
    hot_a    = 5'($urandom);
    hot_b    = 5'($urandom);
    w        = {1'b0, window_len};
    step_max = w / 4;
    if (step_max > step_cap) step_max = step_cap;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99, 0) < hot_pct) begin
        ring = $urandom_range(1, 0) ? hot_a : hot_b;
      end else begin
        ring = 5'($urandom);
      end
      pick = $urandom_range(9, 0);
      if (!long_jumps && pick > 6) pick = 2;
      case (pick)
        0, 1: ;
        2, 3, 4, 5, 6: now_cursor += $urandom_range(step_max, 0);
        7, 8: now_cursor += w + $urandom_range(100, 1);
        default: now_cursor += $urandom;
      endcase
      queue_req(ring[4], ring[3:0], now_cursor);
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : req_drive
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_rsps.insert(expected_rsps.size(), admit_request(in_data_i));
        reqs_accepted++;
        req_gap = draw_wait(in_calm);
      end
      if (!in_valid_i || in_ready_o) begin
        if (req_gap > 0) begin
          req_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_data_i  <= pending_reqs[0];
          in_valid_i <= 1'b1;
          pending_reqs.delete(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    swrl_pkg::rsp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: result beat with nothing expected: admitted=%0d occupancy=%0d",
                   $time, out_data_o.admitted, out_data_o.occupancy);
          errors++;
        end else begin
          want = expected_rsps[0];
          expected_rsps.delete(0);
          if (out_data_o.admitted !== want.admitted) begin
            $display("%0t: admitted mismatch: expected %0d, actual %0d",
                     $time, want.admitted, out_data_o.admitted);
            errors++;
          end
          if (out_data_o.occupancy !== want.occupancy) begin
            $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                     $time, want.occupancy, out_data_o.occupancy);
            errors++;
          end
        end
        if (out_data_o.admitted === 1'b1) admits_seen++;
        else refusals_seen++;
        result_hold = draw_wait(out_calm);
      end else if (out_valid_o && result_hold > 0) begin
        // stall counts down only while a result beat is waiting
        result_hold--;
      end
      out_ready_i <= (result_hold == 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("sliding_window_rate_limiter test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: field extremes and wrap of the tick counter
    queue_req(1'b0, 4'd0,  32'h0000_0000);
    queue_req(1'b1, 4'd15, 32'hFFFF_FFFF);
    queue_req(1'b0, 4'd0,  32'hFFFF_FFFF);
    queue_req(1'b0, 4'd0,  32'h0000_0010);
    queue_req(1'b1, 4'd15, 32'd59999);
    queue_req(1'b1, 4'd15, 32'd60001);
    queue_req(1'b0, 4'd15, 32'h8000_0000);
    settle();

    // limit reached, then window expiry; address limit above capacity
    write_reg(swrl_pkg::CFG_API_LIMIT, 2);
    write_reg(swrl_pkg::CFG_ADDR_LIMIT, 127);
    write_reg(swrl_pkg::CFG_WINDOW_TICKS, 50);
    settings_used++;
    queue_req(1'b0, 4'd5, 32'd1000);
    queue_req(1'b0, 4'd5, 32'd1001);
    queue_req(1'b0, 4'd5, 32'd1002);
    queue_req(1'b0, 4'd5, 32'd1060);
    settle();

    // zero limit still evicts
    write_reg(swrl_pkg::CFG_API_LIMIT, 0);
    settings_used++;
    queue_req(1'b0, 4'd5, 32'd1070);
    queue_req(1'b0, 4'd5, 32'd2000);
    settle();

    // zero window keeps only same-tick stamps
    write_reg(swrl_pkg::CFG_WINDOW_TICKS, 0);
    settings_used++;
    queue_req(1'b1, 4'd7, 32'd500);
    queue_req(1'b1, 4'd7, 32'd500);
    queue_req(1'b1, 4'd7, 32'd501);
    settle();

    now_cursor = $urandom;
    for (int p = 0; p < 6; p++) begin
      write_reg(swrl_pkg::CFG_API_LIMIT, pick_limit());
      write_reg(swrl_pkg::CFG_ADDR_LIMIT, pick_limit());
      write_reg(swrl_pkg::CFG_WINDOW_TICKS, pick_window());
      settings_used++;
      random_traffic(60, 75, 1'b1, 32'hFFFF_FFFF);
      settle();
    end

    // widest window and saturated limits, hot keys packed to full rings
    write_reg(swrl_pkg::CFG_API_LIMIT, 127);
    write_reg(swrl_pkg::CFG_ADDR_LIMIT, swrl_pkg::CFG_W'(DEPTH));
    write_reg(swrl_pkg::CFG_WINDOW_TICKS, 31'h7FFF_FFFF);
    settings_used++;
    random_traffic(150, 95, 1'b0, 32'd1000);
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_rsps.size());
      errors++;
    end
    $display("run covered %0d requests under %0d register settings", reqs_accepted,
             settings_used);
    $display("  %0d admitted, %0d refused, %0d check failures", admits_seen, refusals_seen,
             errors);
    if (errors == 0) begin
      $display("sliding_window_rate_limiter test passed");
    end else begin
      $display("sliding_window_rate_limiter test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
